### hw/rtl/tsd_pkg.sv
// tsd_pkg: constants shared by the touch swipe detector.
// Holds screen geometry, field widths, register map and reset values.
// No dependencies.
package tsd_pkg;

    // Screen geometry and converter resolution
    localparam int SCREEN_WIDTH  = 480;
    localparam int SCREEN_HEIGHT = 320;
    localparam int RAW_BITS      = 12;

    // Width of a reported screen position (positions are masked to this)
    localparam int POS_W = 9;

    // Quotient width of the axis mapping divide: the quotient stays below the screen size
    localparam int SCREEN_MAX = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
    localparam int QW         = $clog2(SCREEN_MAX + 1);
    localparam int NUM_W      = RAW_BITS + QW;
    localparam int DIV_CNT_W  = (QW > 1) ? $clog2(QW) : 1;

    // Square compare widths
    localparam int SQ_OP_W = 10;
    localparam int SQ_W    = 2 * SQ_OP_W;

    // Configuration register indexes
    localparam logic [2:0] REG_PRESSURE_MIN = 3'd0;
    localparam logic [2:0] REG_DEBOUNCE_MS  = 3'd1;
    localparam logic [2:0] REG_X_RAW_LOW    = 3'd2;
    localparam logic [2:0] REG_X_RAW_HIGH   = 3'd3;
    localparam logic [2:0] REG_Y_RAW_LOW    = 3'd4;
    localparam logic [2:0] REG_Y_RAW_HIGH   = 3'd5;
    localparam logic [2:0] REG_SWIPE_TIME   = 3'd6;
    localparam logic [2:0] REG_SWIPE_DIST   = 3'd7;

    // Configuration reset values
    localparam logic [11:0] RST_PRESSURE_MIN = 12'd200;
    localparam logic [15:0] RST_DEBOUNCE_MS  = 16'd20;
    localparam logic [11:0] RST_X_RAW_LOW    = 12'd200;
    localparam logic [11:0] RST_X_RAW_HIGH   = 12'd3900;
    localparam logic [11:0] RST_Y_RAW_LOW    = 12'd200;
    localparam logic [11:0] RST_Y_RAW_HIGH   = 12'd3900;
    localparam logic [15:0] RST_SWIPE_TIME   = 16'd500;
    localparam logic [9:0]  RST_SWIPE_DIST   = 10'd50;

    // Swipe direction codes
    localparam logic [1:0] DIR_RIGHT = 2'd0;
    localparam logic [1:0] DIR_LEFT  = 2'd1;
    localparam logic [1:0] DIR_DOWN  = 2'd2;
    localparam logic [1:0] DIR_UP    = 2'd3;

endpackage

### hw/rtl/touch_swipe_detector.sv
// touch_swipe_detector: press/release and swipe detection on raw touch samples.
// Uses tsd_pkg for geometry, register map and reset values.
//
//   channel  | direction | handshake      | payload
//   ---------+-----------+----------------+------------------------------------------
//   s_       | in        | s_valid/ready  | raw_x, raw_y, raw_z, now_ms
//   m_       | out       | m_valid/ready  | touch event fields, swipe fields
//   apb      | in        | psel/penable   | 8 config registers at 4*index
//
// A touching sample that starts or continues a press is mapped by the shared restoring
// divider, x then y, one quotient bit per cycle; a value clamped at a calibration limit
// skips its divide. A sample that ends a tracked press within the swipe time then runs
// the squared distance test on the shared multiplier in the states SQ0, SQ1 and SQ2.
// s_ready is high only in idle; a finished result waits in the output register
// while the next sample is taken. Reset is synchronous, active low, no clearing pass.
module touch_swipe_detector (
    input  logic        aclk,
    input  logic        aresetn,
    // sample channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [11:0] s_raw_x,
    input  logic [11:0] s_raw_y,
    input  logic [11:0] s_raw_z,
    input  logic [31:0] s_now_ms,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_touch_valid,
    output logic        m_touch_pressed,
    output logic [8:0]  m_touch_x,
    output logic [8:0]  m_touch_y,
    output logic        m_swipe_valid,
    output logic [1:0]  m_swipe_dir,
    output logic [8:0]  m_swipe_from_x,
    output logic [8:0]  m_swipe_from_y,
    output logic [8:0]  m_swipe_to_x,
    output logic [8:0]  m_swipe_to_y,
    output logic [15:0] m_swipe_ms,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int RB = tsd_pkg::RAW_BITS;
    localparam int PW = tsd_pkg::POS_W;
    localparam int QW = tsd_pkg::QW;
    localparam int NW = tsd_pkg::NUM_W;
    localparam int CW = tsd_pkg::DIV_CNT_W;

    // Sequencer states
    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_DECIDE = 4'd1;
    localparam logic [3:0] ST_MAP    = 4'd2;
    localparam logic [3:0] ST_DIV    = 4'd3;
    localparam logic [3:0] ST_PRESS  = 4'd4;
    localparam logic [3:0] ST_TRACK  = 4'd5;
    localparam logic [3:0] ST_SQ0    = 4'd6;
    localparam logic [3:0] ST_SQ1    = 4'd7;
    localparam logic [3:0] ST_SQ2    = 4'd8;
    localparam logic [3:0] ST_OUT    = 4'd9;

    // Configuration registers
    logic [11:0] pressure_min_reg;
    logic [15:0] debounce_ms_reg;
    logic [11:0] x_raw_low_reg;
    logic [11:0] x_raw_high_reg;
    logic [11:0] y_raw_low_reg;
    logic [11:0] y_raw_high_reg;
    logic [15:0] swipe_time_reg;
    logic [9:0]  swipe_dist_reg;

    // Control state
    logic [3:0]  state_reg, state_next;
    logic        pen_down_reg;
    logic        last_pos_valid_reg;
    logic        tracking_reg;
    logic        m_valid_reg;

    // Tracking state (cleared by reset to match the behavior after reset)
    logic [31:0]   last_act_reg;
    logic [PW-1:0] last_x_reg;
    logic [PW-1:0] last_y_reg;
    logic [PW-1:0] start_x_reg;
    logic [PW-1:0] start_y_reg;
    logic [31:0]   start_ms_reg;

    // Working registers
    logic [11:0]   raw_x_reg;
    logic [11:0]   raw_y_reg;
    logic [11:0]   raw_z_reg;
    logic [31:0]   now_reg;
    logic          axis_reg;
    logic [RB-1:0] rem_reg;
    logic [QW-1:0] quo_reg;
    logic [RB-1:0] den_reg;
    logic [CW-1:0] cnt_reg;
    logic [PW-1:0] map_x_reg;
    logic          ev_valid_reg;
    logic          ev_pressed_reg;
    logic [PW-1:0] ev_x_reg;
    logic [PW-1:0] ev_y_reg;
    logic          hit_reg;
    logic [1:0]    dir_reg;
    logic [15:0]   dur_reg;
    logic [PW-1:0] ax_reg;
    logic [PW-1:0] ay_reg;
    logic [tsd_pkg::SQ_W-1:0] acc_reg;

    // Output registers
    logic          o_touch_valid_reg;
    logic          o_touch_pressed_reg;
    logic [8:0]    o_touch_x_reg;
    logic [8:0]    o_touch_y_reg;
    logic          o_swipe_valid_reg;
    logic [1:0]    o_swipe_dir_reg;
    logic [8:0]    o_from_x_reg;
    logic [8:0]    o_from_y_reg;
    logic [8:0]    o_to_x_reg;
    logic [8:0]    o_to_y_reg;
    logic [15:0]   o_ms_reg;

    // Combinational helpers
    logic          cfg_write;
    logic          in_xfer;
    logic          out_free;
    logic          touching;
    logic          press_ok;
    logic [31:0]   since_act;
    logic [31:0]   dur_full;
    logic [RB-1:0] map_raw, map_lo, map_hi;
    logic [NW-1:0] map_num;
    logic [PW-1:0] map_size;
    logic [RB:0]   div_cand;
    logic          div_ge;
    logic [RB:0]   div_diff;
    logic [PW-1:0] div_pos;
    logic [tsd_pkg::SQ_OP_W-1:0] mul_op;
    logic [tsd_pkg::SQ_W-1:0]    mul_prod;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign in_xfer   = s_valid & s_ready;
    assign out_free  = ~m_valid_reg | m_ready;

    // Register readback
    always_comb begin
        unique case (paddr[4:2])
            tsd_pkg::REG_PRESSURE_MIN: prdata = {20'd0, pressure_min_reg};
            tsd_pkg::REG_DEBOUNCE_MS:  prdata = {16'd0, debounce_ms_reg};
            tsd_pkg::REG_X_RAW_LOW:    prdata = {20'd0, x_raw_low_reg};
            tsd_pkg::REG_X_RAW_HIGH:   prdata = {20'd0, x_raw_high_reg};
            tsd_pkg::REG_Y_RAW_LOW:    prdata = {20'd0, y_raw_low_reg};
            tsd_pkg::REG_Y_RAW_HIGH:   prdata = {20'd0, y_raw_high_reg};
            tsd_pkg::REG_SWIPE_TIME:   prdata = {16'd0, swipe_time_reg};
            tsd_pkg::REG_SWIPE_DIST:   prdata = {22'd0, swipe_dist_reg};
            default:                   prdata = 32'd0;
        endcase
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pressure_min_reg <= tsd_pkg::RST_PRESSURE_MIN;
            debounce_ms_reg  <= tsd_pkg::RST_DEBOUNCE_MS;
            x_raw_low_reg    <= tsd_pkg::RST_X_RAW_LOW;
            x_raw_high_reg   <= tsd_pkg::RST_X_RAW_HIGH;
            y_raw_low_reg    <= tsd_pkg::RST_Y_RAW_LOW;
            y_raw_high_reg   <= tsd_pkg::RST_Y_RAW_HIGH;
            swipe_time_reg   <= tsd_pkg::RST_SWIPE_TIME;
            swipe_dist_reg   <= tsd_pkg::RST_SWIPE_DIST;
        end else if (cfg_write) begin
            unique case (paddr[4:2])
                tsd_pkg::REG_PRESSURE_MIN: pressure_min_reg <= pwdata[11:0];
                tsd_pkg::REG_DEBOUNCE_MS:  debounce_ms_reg  <= pwdata[15:0];
                tsd_pkg::REG_X_RAW_LOW:    x_raw_low_reg    <= pwdata[11:0];
                tsd_pkg::REG_X_RAW_HIGH:   x_raw_high_reg   <= pwdata[11:0];
                tsd_pkg::REG_Y_RAW_LOW:    y_raw_low_reg    <= pwdata[11:0];
                tsd_pkg::REG_Y_RAW_HIGH:   y_raw_high_reg   <= pwdata[11:0];
                tsd_pkg::REG_SWIPE_TIME:   swipe_time_reg   <= pwdata[15:0];
                tsd_pkg::REG_SWIPE_DIST:   swipe_dist_reg   <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    // Press decision
    assign touching  = (raw_z_reg >= pressure_min_reg);
    assign since_act = now_reg - last_act_reg;
    assign press_ok  = touching & (pen_down_reg | (since_act >= {16'd0, debounce_ms_reg}));
    assign dur_full  = now_reg - start_ms_reg;

    // Axis select for the shared mapping divider
    assign map_raw  = axis_reg ? RB'(raw_y_reg) : RB'(raw_x_reg);
    assign map_lo   = axis_reg ? RB'(y_raw_low_reg) : RB'(x_raw_low_reg);
    assign map_hi   = axis_reg ? RB'(y_raw_high_reg) : RB'(x_raw_high_reg);
    assign map_size = axis_reg ? PW'(tsd_pkg::SCREEN_HEIGHT) : PW'(tsd_pkg::SCREEN_WIDTH);
    assign map_num  = NW'(map_raw - map_lo) *
                      (axis_reg ? NW'(tsd_pkg::SCREEN_HEIGHT) : NW'(tsd_pkg::SCREEN_WIDTH));

    // One restoring divide step
    assign div_cand = {rem_reg, quo_reg[QW-1]};
    assign div_ge   = (div_cand >= {1'b0, den_reg});
    assign div_diff = div_cand - {1'b0, den_reg};
    assign div_pos  = PW'({quo_reg[QW-2:0], div_ge});

    // Shared multiplier for the squared distance test
    always_comb begin
        priority case (state_reg)
            ST_SQ0:  mul_op = tsd_pkg::SQ_OP_W'(ax_reg);
            ST_SQ1:  mul_op = tsd_pkg::SQ_OP_W'(ay_reg);
            default: mul_op = swipe_dist_reg;
        endcase
    end
    assign mul_prod = mul_op * mul_op;

    // Sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (in_xfer) state_next = ST_DECIDE;
            ST_DECIDE: state_next = press_ok ? ST_MAP : ST_TRACK;
            ST_MAP: begin
                if (map_raw <= map_lo || map_raw >= map_hi) begin
                    state_next = axis_reg ? ST_PRESS : ST_MAP;
                end else begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (cnt_reg == CW'(QW - 1)) state_next = axis_reg ? ST_PRESS : ST_MAP;
            end
            ST_PRESS:  state_next = ST_OUT;
            ST_TRACK: begin
                if (tracking_reg && dur_full < {16'd0, swipe_time_reg} && last_pos_valid_reg)
                    state_next = ST_SQ0;
                else
                    state_next = ST_OUT;
            end
            ST_SQ0:    state_next = ST_SQ1;
            ST_SQ1:    state_next = ST_SQ2;
            ST_SQ2:    state_next = ST_OUT;
            ST_OUT:    if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Control and tracking state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_IDLE;
            pen_down_reg       <= 1'b0;
            last_pos_valid_reg <= 1'b0;
            tracking_reg       <= 1'b0;
            m_valid_reg        <= 1'b0;
            last_act_reg       <= 32'd0;
            last_x_reg         <= '0;
            last_y_reg         <= '0;
            start_x_reg        <= '0;
            start_y_reg        <= '0;
            start_ms_reg       <= 32'd0;
        end else begin
            state_reg <= state_next;
            // raise valid on a loaded result, hold it until the transfer
            m_valid_reg <= (state_reg == ST_OUT && out_free) || (m_valid_reg && !m_ready);
            unique case (state_reg)
                ST_DECIDE: begin
                    // drop the pen on a release
                    if (!touching && pen_down_reg) begin
                        pen_down_reg <= 1'b0;
                        last_act_reg <= now_reg;
                    end
                end
                ST_PRESS: begin
                    pen_down_reg       <= 1'b1;
                    last_x_reg         <= map_x_reg;
                    last_y_reg         <= ev_y_reg;
                    last_pos_valid_reg <= 1'b1;
                    last_act_reg       <= now_reg;
                    if (!tracking_reg) begin
                        tracking_reg <= 1'b1;
                        start_x_reg  <= map_x_reg;
                        start_y_reg  <= ev_y_reg;
                        start_ms_reg <= now_reg;
                    end
                end
                ST_TRACK:  tracking_reg <= 1'b0;
                default: ;
            endcase
        end
    end

    // Datapath working registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    raw_x_reg <= s_raw_x;
                    raw_y_reg <= s_raw_y;
                    raw_z_reg <= s_raw_z;
                    now_reg   <= s_now_ms;
                end
            end
            ST_DECIDE: begin
                axis_reg       <= 1'b0;
                hit_reg        <= 1'b0;
                ev_pressed_reg <= 1'b0;
                if (!touching && pen_down_reg) begin
                    ev_valid_reg <= 1'b1;
                    ev_x_reg     <= last_x_reg;
                    ev_y_reg     <= last_y_reg;
                end else begin
                    ev_valid_reg <= 1'b0;
                    ev_x_reg     <= '0;
                    ev_y_reg     <= '0;
                end
            end
            ST_MAP: begin
                // clamp outside the calibration window, else start the divide
                if (map_raw <= map_lo || map_raw >= map_hi) begin
                    if (axis_reg) ev_y_reg <= (map_raw <= map_lo) ? '0 : map_size;
                    else          map_x_reg <= (map_raw <= map_lo) ? '0 : map_size;
                    axis_reg <= 1'b1;
                end else begin
                    rem_reg <= map_num[NW-1:QW];
                    quo_reg <= map_num[QW-1:0];
                    den_reg <= map_hi - map_lo;
                    cnt_reg <= '0;
                end
            end
            ST_DIV: begin
                // advance one quotient bit
                rem_reg <= div_ge ? div_diff[RB-1:0] : div_cand[RB-1:0];
                quo_reg <= {quo_reg[QW-2:0], div_ge};
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(QW - 1)) begin
                    if (axis_reg) ev_y_reg <= div_pos;
                    else          map_x_reg <= div_pos;
                    axis_reg <= 1'b1;
                end
            end
            ST_PRESS: begin
                ev_valid_reg   <= 1'b1;
                ev_pressed_reg <= 1'b1;
                ev_x_reg       <= map_x_reg;
            end
            ST_TRACK: begin
                // capture movement, direction and duration for the distance test
                dur_reg <= dur_full[15:0];
                ax_reg  <= (last_x_reg > start_x_reg) ? last_x_reg - start_x_reg
                                                      : start_x_reg - last_x_reg;
                ay_reg  <= (last_y_reg > start_y_reg) ? last_y_reg - start_y_reg
                                                      : start_y_reg - last_y_reg;
                if (((last_x_reg > start_x_reg) ? last_x_reg - start_x_reg
                                                : start_x_reg - last_x_reg) >
                    ((last_y_reg > start_y_reg) ? last_y_reg - start_y_reg
                                                : start_y_reg - last_y_reg))
                    dir_reg <= (last_x_reg > start_x_reg) ? tsd_pkg::DIR_RIGHT
                                                          : tsd_pkg::DIR_LEFT;
                else
                    dir_reg <= (last_y_reg > start_y_reg) ? tsd_pkg::DIR_DOWN
                                                          : tsd_pkg::DIR_UP;
            end
            ST_SQ0:  acc_reg <= mul_prod;
            ST_SQ1:  acc_reg <= acc_reg + mul_prod;
            ST_SQ2:  hit_reg <= (acc_reg >= mul_prod);
            default: ;
        endcase
    end

    // Output register: load the result transfer
    always_ff @(posedge aclk) begin
        if (state_reg == ST_OUT && out_free) begin
            o_touch_valid_reg   <= ev_valid_reg;
            o_touch_pressed_reg <= ev_pressed_reg;
            o_touch_x_reg       <= 9'(ev_x_reg);
            o_touch_y_reg       <= 9'(ev_y_reg);
            o_swipe_valid_reg   <= hit_reg;
            o_swipe_dir_reg     <= hit_reg ? dir_reg : 2'd0;
            o_from_x_reg        <= hit_reg ? 9'(start_x_reg) : 9'd0;
            o_from_y_reg        <= hit_reg ? 9'(start_y_reg) : 9'd0;
            o_to_x_reg          <= hit_reg ? 9'(last_x_reg) : 9'd0;
            o_to_y_reg          <= hit_reg ? 9'(last_y_reg) : 9'd0;
            o_ms_reg            <= hit_reg ? dur_reg : 16'd0;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_touch_valid   = o_touch_valid_reg;
    assign m_touch_pressed = o_touch_pressed_reg;
    assign m_touch_x       = o_touch_x_reg;
    assign m_touch_y       = o_touch_y_reg;
    assign m_swipe_valid   = o_swipe_valid_reg;
    assign m_swipe_dir     = o_swipe_dir_reg;
    assign m_swipe_from_x  = o_from_x_reg;
    assign m_swipe_from_y  = o_from_y_reg;
    assign m_swipe_to_x    = o_to_x_reg;
    assign m_swipe_to_y    = o_to_y_reg;
    assign m_swipe_ms      = o_ms_reg;

    // Checks
    a_busy_after_take: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> !s_ready)
        else $error("sample taken while a previous one is in work");

    a_div_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (cnt_reg <= CW'(QW - 1)))
        else $error("divide step count past quotient width");

    a_swipe_on_release: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_swipe_valid) |-> !m_touch_pressed)
        else $error("swipe reported on a press event");

    a_pressed_is_event: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_touch_pressed) |-> m_touch_valid)
        else $error("press flag without a touch event");

endmodule

### tb/sv/tb_touch_swipe_detector.sv
// Self-checking testbench for touch_swipe_detector: press, release and swipe results
// are predicted per sample and compared field by field on the result channel.
// Depends on tsd_pkg and the touch_swipe_detector RTL.
module tb_touch_swipe_detector;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int HOLD_CYCLES   = 400;
    localparam int IDLE_PCT      = 25;
    localparam int SETTLE_CYCLES = 40;

    typedef struct {
        logic [11:0] raw_x;
        logic [11:0] raw_y;
        logic [11:0] raw_z;
        logic [31:0] now_ms;
    } touch_sample_t;

    typedef struct {
        logic       touch_valid;
        logic       touch_pressed;
        logic [8:0] touch_x;
        logic [8:0] touch_y;
        logic       swipe_valid;
        logic [1:0] swipe_dir;
        logic [8:0] from_x;
        logic [8:0] from_y;
        logic [8:0] to_x;
        logic [8:0] to_y;
        logic [15:0] swipe_ms;
    } touch_result_t;

    // Block ports
    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_valid  = 1'b0;
    logic        s_ready;
    logic [11:0] s_raw_x  = '0;
    logic [11:0] s_raw_y  = '0;
    logic [11:0] s_raw_z  = '0;
    logic [31:0] s_now_ms = '0;
    logic        m_valid;
    logic        m_ready  = 1'b0;
    logic        m_touch_valid;
    logic        m_touch_pressed;
    logic [8:0]  m_touch_x;
    logic [8:0]  m_touch_y;
    logic        m_swipe_valid;
    logic [1:0]  m_swipe_dir;
    logic [8:0]  m_swipe_from_x;
    logic [8:0]  m_swipe_from_y;
    logic [8:0]  m_swipe_to_x;
    logic [8:0]  m_swipe_to_y;
    logic [15:0] m_swipe_ms;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [4:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    // Register copies used by the predictor
    logic [11:0] cfg_pressure  = tsd_pkg::RST_PRESSURE_MIN;
    logic [15:0] cfg_debounce  = tsd_pkg::RST_DEBOUNCE_MS;
    logic [11:0] cfg_xlo       = tsd_pkg::RST_X_RAW_LOW;
    logic [11:0] cfg_xhi       = tsd_pkg::RST_X_RAW_HIGH;
    logic [11:0] cfg_ylo       = tsd_pkg::RST_Y_RAW_LOW;
    logic [11:0] cfg_yhi       = tsd_pkg::RST_Y_RAW_HIGH;
    logic [15:0] cfg_swipe_ms  = tsd_pkg::RST_SWIPE_TIME;
    logic [9:0]  cfg_min_dist  = tsd_pkg::RST_SWIPE_DIST;

    // Gesture state of the predictor
    logic        pen_is_down  = 1'b0;
    logic        pos_seen     = 1'b0;
    logic        gesture_open = 1'b0;
    logic [31:0] activity_ms  = '0;
    logic [31:0] origin_ms    = '0;
    logic [8:0]  cur_x        = '0;
    logic [8:0]  cur_y        = '0;
    logic [8:0]  origin_x     = '0;
    logic [8:0]  origin_y     = '0;

    touch_sample_t pending_samples[$];
    touch_result_t expected_results[$];

    int          errors       = 0;
    int          queued_items = 0;
    int          cycle_count  = 0;
    int          hold_req     = 0;
    int          hold_ack     = 0;
    int          hold_left    = 0;
    bit          no_idle      = 1'b0;
    bit          s_took       = 1'b0;
    logic [31:0] sim_ms       = '0;

    always #5 aclk = ~aclk;

    touch_swipe_detector DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_raw_x         (s_raw_x),
        .s_raw_y         (s_raw_y),
        .s_raw_z         (s_raw_z),
        .s_now_ms        (s_now_ms),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_touch_valid   (m_touch_valid),
        .m_touch_pressed (m_touch_pressed),
        .m_touch_x       (m_touch_x),
        .m_touch_y       (m_touch_y),
        .m_swipe_valid   (m_swipe_valid),
        .m_swipe_dir     (m_swipe_dir),
        .m_swipe_from_x  (m_swipe_from_x),
        .m_swipe_from_y  (m_swipe_from_y),
        .m_swipe_to_x    (m_swipe_to_x),
        .m_swipe_to_y    (m_swipe_to_y),
        .m_swipe_ms      (m_swipe_ms),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // Clamp a raw reading to the calibration window and scale it to screen units
    function automatic logic [8:0] scale_axis(input logic [11:0] raw, input logic [11:0] lo,
                                              input logic [11:0] hi, input int unsigned span);
        int unsigned q;
        if (raw <= lo)
            q = 0;
        else if (raw >= hi)
            q = span;
        else
            q = ((raw - lo) * span) / (hi - lo);
        return q[8:0];
    endfunction

    // Advance the gesture state by one sample and return the result it yields
    function automatic touch_result_t predict_gesture(input touch_sample_t smp);
        touch_result_t r;
        logic [31:0]   dur;
        int            dx, dy, ax, ay;
        r = '{default: '0};
        if (smp.raw_z < cfg_pressure) begin
            if (pen_is_down) begin
                r.touch_valid = 1'b1;
                r.touch_x     = cur_x;
                r.touch_y     = cur_y;
                pen_is_down   = 1'b0;
                activity_ms   = smp.now_ms;
            end
        end else if (pen_is_down || (smp.now_ms - activity_ms) >= {16'd0, cfg_debounce}) begin
            pen_is_down     = 1'b1;
            r.touch_valid   = 1'b1;
            r.touch_pressed = 1'b1;
            r.touch_x       = scale_axis(smp.raw_x, cfg_xlo, cfg_xhi, tsd_pkg::SCREEN_WIDTH);
            r.touch_y       = scale_axis(smp.raw_y, cfg_ylo, cfg_yhi, tsd_pkg::SCREEN_HEIGHT);
            cur_x           = r.touch_x;
            cur_y           = r.touch_y;
            pos_seen        = 1'b1;
            activity_ms     = smp.now_ms;
        end

        if (r.touch_pressed) begin
            if (!gesture_open) begin
                gesture_open = 1'b1;
                origin_x     = r.touch_x;
                origin_y     = r.touch_y;
                origin_ms    = smp.now_ms;
            end
        end else if (gesture_open) begin
            // Evaluate the finished press as a swipe candidate
            dur = smp.now_ms - origin_ms;
            if (dur < {16'd0, cfg_swipe_ms} && pos_seen) begin
                dx = int'(cur_x) - int'(origin_x);
                dy = int'(cur_y) - int'(origin_y);
                ax = (dx < 0) ? -dx : dx;
                ay = (dy < 0) ? -dy : dy;
                if (ax * ax + ay * ay >= int'(cfg_min_dist) * int'(cfg_min_dist)) begin
                    r.swipe_valid = 1'b1;
                    if (ax > ay)
                        r.swipe_dir = (dx > 0) ? tsd_pkg::DIR_RIGHT : tsd_pkg::DIR_LEFT;
                    else
                        r.swipe_dir = (dy > 0) ? tsd_pkg::DIR_DOWN : tsd_pkg::DIR_UP;
                    r.from_x   = origin_x;
                    r.from_y   = origin_y;
                    r.to_x     = cur_x;
                    r.to_y     = cur_y;
                    r.swipe_ms = dur[15:0];
                end
            end
            gesture_open = 1'b0;
        end
        return r;
    endfunction

    function void check_field(input string fname, input logic [31:0] want,
                              input logic [31:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
        end
    endfunction

    // Check result transfers, then record the input transfer of this edge
    always @(posedge aclk) begin : result_watch
        touch_result_t want;
        touch_sample_t got_in;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t: result transfer with nothing expected, actual touch_x %0d",
                         $time, m_touch_x);
            end else begin
                want = expected_results.pop_front();
                check_field("touch_valid", 32'(want.touch_valid), 32'(m_touch_valid));
                check_field("touch_pressed", 32'(want.touch_pressed), 32'(m_touch_pressed));
                check_field("touch_x", 32'(want.touch_x), 32'(m_touch_x));
                check_field("touch_y", 32'(want.touch_y), 32'(m_touch_y));
                check_field("swipe_valid", 32'(want.swipe_valid), 32'(m_swipe_valid));
                check_field("swipe_dir", 32'(want.swipe_dir), 32'(m_swipe_dir));
                check_field("swipe_from_x", 32'(want.from_x), 32'(m_swipe_from_x));
                check_field("swipe_from_y", 32'(want.from_y), 32'(m_swipe_from_y));
                check_field("swipe_to_x", 32'(want.to_x), 32'(m_swipe_to_x));
                check_field("swipe_to_y", 32'(want.to_y), 32'(m_swipe_to_y));
                check_field("swipe_ms", 32'(want.swipe_ms), 32'(m_swipe_ms));
            end
        end
        s_took = aresetn && s_valid && s_ready;
        if (s_took) begin
            got_in.raw_x  = s_raw_x;
            got_in.raw_y  = s_raw_y;
            got_in.raw_z  = s_raw_z;
            got_in.now_ms = s_now_ms;
            expected_results.push_back(predict_gesture(got_in));
        end
    end

    // Offer pending samples, idling at random between transfers
    always @(negedge aclk) begin : sample_drive
        touch_sample_t nxt;
        if (aresetn && (!s_valid || s_took)) begin
            if (pending_samples.size() != 0 &&
                (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
                nxt = pending_samples.pop_front();
                s_valid  <= 1'b1;
                s_raw_x  <= nxt.raw_x;
                s_raw_y  <= nxt.raw_y;
                s_raw_z  <= nxt.raw_z;
                s_now_ms <= nxt.now_ms;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Accept results at random; hold off for a long stretch on request
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req != hold_ack) begin
            m_ready   <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_ack  <= hold_req;
        end else begin
            m_ready <= aresetn && (no_idle || $urandom_range(99) >= IDLE_PCT);
        end
    end

    // Bound the run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            tsd_pkg::REG_PRESSURE_MIN: cfg_pressure = val[11:0];
            tsd_pkg::REG_DEBOUNCE_MS:  cfg_debounce = val[15:0];
            tsd_pkg::REG_X_RAW_LOW:    cfg_xlo      = val[11:0];
            tsd_pkg::REG_X_RAW_HIGH:   cfg_xhi      = val[11:0];
            tsd_pkg::REG_Y_RAW_LOW:    cfg_ylo      = val[11:0];
            tsd_pkg::REG_Y_RAW_HIGH:   cfg_yhi      = val[11:0];
            tsd_pkg::REG_SWIPE_TIME:   cfg_swipe_ms = val[15:0];
            tsd_pkg::REG_SWIPE_DIST:   cfg_min_dist = val[9:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input int pmin, input int deb, input int xl, input int xh,
                              input int yl, input int yh, input int tlim, input int dmin);
        reg_write(tsd_pkg::REG_PRESSURE_MIN, pmin);
        reg_write(tsd_pkg::REG_DEBOUNCE_MS, deb);
        reg_write(tsd_pkg::REG_X_RAW_LOW, xl);
        reg_write(tsd_pkg::REG_X_RAW_HIGH, xh);
        reg_write(tsd_pkg::REG_Y_RAW_LOW, yl);
        reg_write(tsd_pkg::REG_Y_RAW_HIGH, yh);
        reg_write(tsd_pkg::REG_SWIPE_TIME, tlim);
        reg_write(tsd_pkg::REG_SWIPE_DIST, dmin);
    endtask

    task automatic push_sample(input logic [11:0] x, input logic [11:0] y,
                               input logic [11:0] z, input logic [31:0] t);
        touch_sample_t smp;
        smp.raw_x  = x;
        smp.raw_y  = y;
        smp.raw_z  = z;
        smp.now_ms = t;
        pending_samples.push_back(smp);
        queued_items++;
    endtask

    // Wait until every sample is taken and every result has come back
    task automatic wait_drained();
        while (pending_samples.size() != 0 || s_valid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    function automatic logic [11:0] touch_z();
        return 12'($urandom_range(4095, cfg_pressure));
    endfunction

    function automatic logic [11:0] lift_z();
        if (cfg_pressure == 0)
            return 12'($urandom_range(4095));
        return 12'($urandom_range(cfg_pressure - 1));
    endfunction

    // Pick a gesture end point: unmoved, nearby or anywhere
    function automatic int end_point(input int a);
        case ($urandom_range(2))
            0: return a;
            1: return a ^ $urandom_range(511);
            default: return $urandom_range(4095);
        endcase
    endfunction

    // Queue a press that moves in a straight line, then a release
    task automatic add_gesture();
        int n, xa, ya, xb, yb, div;
        case ($urandom_range(3))
            0: sim_ms += $urandom_range(5);
            1: sim_ms += {16'd0, cfg_debounce} + $urandom_range(4) - 2;
            default: sim_ms += $urandom_range(70000);
        endcase
        xa  = $urandom_range(4095);
        ya  = $urandom_range(4095);
        xb  = end_point(xa);
        yb  = end_point(ya);
        n   = $urandom_range(12, 1);
        div = (n > 1) ? n - 1 : 1;
        for (int k = 0; k < n; k++) begin
            if (k > 0)
                sim_ms += ($urandom_range(3) == 0) ? $urandom_range(400) : $urandom_range(40);
            push_sample(12'(xa + (xb - xa) * k / div), 12'(ya + (yb - ya) * k / div),
                        touch_z(), sim_ms);
        end
        sim_ms += $urandom_range(40);
        push_sample(12'($urandom_range(4095)), 12'($urandom_range(4095)), lift_z(), sim_ms);
    endtask

    // Queue a lone tap whose release is followed at once by a bouncing press
    task automatic add_bounce();
        sim_ms += $urandom_range(100);
        push_sample(12'($urandom_range(4095)), 12'($urandom_range(4095)), touch_z(), sim_ms);
        sim_ms += $urandom_range(2000);
        push_sample(12'($urandom_range(4095)), 12'($urandom_range(4095)), lift_z(), sim_ms);
        sim_ms += $urandom_range(2);
        push_sample(12'($urandom_range(4095)), 12'($urandom_range(4095)), touch_z(), sim_ms);
    endtask

    task automatic run_random(input int n);
        int target;
        int pick;
        target = queued_items + n;
        while (queued_items < target) begin
            pick = $urandom_range(99);
            if (pick < 80)
                add_gesture();
            else if (pick < 90)
                push_sample(12'($urandom_range(4095)), 12'($urandom_range(4095)),
                            12'($urandom_range(4095)), $urandom());
            else
                add_bounce();
        end
        wait_drained();
    endtask

    initial begin
        int xl, xh, yl, yh, tmp;

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part on reset configuration: edges, directions and special cases
        push_sample(12'd2000, 12'd2000, 12'd199, 32'd100);     // below threshold, pen up
        push_sample(12'd0, 12'd0, 12'd200, 32'd1000);          // clamp at low corner
        push_sample(12'd4095, 12'd4095, 12'd4095, 32'd1100);   // clamp at high corner
        push_sample(12'd0, 12'd0, 12'd0, 32'd1200);            // release: swipe right
        push_sample(12'd2000, 12'd2000, 12'd300, 32'd1210);    // press inside debounce
        push_sample(12'd3900, 12'd200, 12'd300, 32'd1220);     // debounce exactly elapsed
        push_sample(12'd200, 12'd3900, 12'd300, 32'd1230);
        push_sample(12'd0, 12'd0, 12'd10, 32'd1240);           // swipe left
        push_sample(12'd2050, 12'd200, 12'd300, 32'd1300);
        push_sample(12'd2050, 12'd3900, 12'd300, 32'd1310);
        push_sample(12'd0, 12'd0, 12'd10, 32'd1320);           // swipe down
        push_sample(12'd2050, 12'd3900, 12'd300, 32'd1400);
        push_sample(12'd2050, 12'd200, 12'd300, 32'd1410);
        push_sample(12'd0, 12'd0, 12'd10, 32'd1420);           // swipe up
        push_sample(12'd0, 12'd0, 12'd300, 32'd1500);
        push_sample(12'd971, 12'd1357, 12'd300, 32'd1510);
        push_sample(12'd0, 12'd0, 12'd10, 32'd1520);           // equal movement: vertical
        push_sample(12'd2050, 12'd2050, 12'd300, 32'd1600);
        push_sample(12'd2060, 12'd2060, 12'd300, 32'd1610);
        push_sample(12'd0, 12'd0, 12'd10, 32'd1620);           // too short a move
        push_sample(12'd0, 12'd0, 12'd300, 32'd2000);
        push_sample(12'd4095, 12'd4095, 12'd10, 32'd2600);     // too long a press
        push_sample(12'd0, 12'd2050, 12'd300, 32'hFFFF_FFF0);
        push_sample(12'd4095, 12'd2050, 12'd300, 32'h0000_0005);
        push_sample(12'd0, 12'd0, 12'd10, 32'h0000_0010);      // swipe across time wrap
        wait_drained();

        // Zero distance, full-range calibration, widest time window
        sim_ms = 32'd5000;
        set_config(200, 0, 0, 4095, 0, 4095, 65535, 0);
        run_random(120);

        // Inverted and collapsed calibration, highest thresholds, no time window
        set_config(4095, 65535, 4095, 0, 3000, 3000, 0, 1023);
        run_random(60);

        // Every sample touches
        set_config(0, 20, 200, 3900, 200, 3900, 500, 600);
        run_random(40);

        // Receiver holds off while samples keep coming; time wraps during the phase
        sim_ms = 32'hFFFF_F000;
        set_config(int'(tsd_pkg::RST_PRESSURE_MIN), int'(tsd_pkg::RST_DEBOUNCE_MS),
                   int'(tsd_pkg::RST_X_RAW_LOW), int'(tsd_pkg::RST_X_RAW_HIGH),
                   int'(tsd_pkg::RST_Y_RAW_LOW), int'(tsd_pkg::RST_Y_RAW_HIGH),
                   int'(tsd_pkg::RST_SWIPE_TIME), int'(tsd_pkg::RST_SWIPE_DIST));
        hold_req++;
        run_random(150);

        // Back-to-back transfers on both sides
        no_idle = 1'b1;
        run_random(120);
        no_idle = 1'b0;

        // Random settings, one of them with the x window inverted
        for (int ph = 0; ph < 4; ph++) begin
            xl = $urandom_range(1200);
            xh = $urandom_range(4095, 2800);
            yl = $urandom_range(1200);
            yh = $urandom_range(4095, 2800);
            if (ph == 1) begin
                tmp = xl;
                xl  = xh;
                xh  = tmp;
            end
            set_config($urandom_range(1500), $urandom_range(60), xl, xh, yl, yh,
                       $urandom_range(1000, 100), $urandom_range(200));
            run_random(100);
        end

        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
